// ----- hdl/chbd_pkg.sv -----
// Shared types, constants and the byte classifier of the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
package chbd_pkg;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  localparam int HEX_RADIX = 16;
  localparam int DEC_RADIX = 10;

  localparam int BODY_W   = 32;
  localparam int LINE_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE = 8'd1;

  localparam logic [BODY_W-1:0] MAX_BODY_RST = 32'd16777216;
  localparam logic [LINE_W-1:0] MAX_LINE_RST = 16'd8192;

  localparam logic [1:0] ST_WORK = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_BIG  = 2'd3;

  typedef struct packed {
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       is_ws;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
    char_cls_t  cls;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
  } result_t;

  function automatic char_cls_t classify(input logic [7:0] c);
    char_cls_t r;
    r = '0;
    r.is_cr   = (c == CH_CR);
    r.is_lf   = (c == CH_LF);
    r.is_semi = (c == CH_SEMI);
    r.is_ws   = (c == CH_SP) || (c == CH_TAB);
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex  = 1'b1;
      r.hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.is_hex  = 1'b1;
      r.hex_val = 4'(c - 8'h61 + 8'(DEC_RADIX));
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.is_hex  = 1'b1;
      r.hex_val = 4'(c - 8'h41 + 8'(DEC_RADIX));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/http_chunked_body_decoder.sv -----
// Top level of the HTTP chunked body decoder: front queue, engine, result queue.
//
// Raw body bytes enter through push/full with in_data_byte and in_new_message;
// in_new_message restarts decoding with that byte as the first of a new body.
// Every accepted byte yields exactly one result word: out_payload_valid and
// out_payload_byte carry a decoded data byte, out_status reports working,
// complete, malformed or too large. Complete and error states are sticky
// until the next new_message. Results wait in a two-entry queue and are taken
// with pop while empty is low.
// A byte passes through the input queue and the engine and is written into the
// result queue, which then lowers empty; one byte per cycle is sustained while
// the result queue has room, set by the single decode step of the engine.
// A stalled receiver fills the result queue, the engine then holds, the
// two-entry input queue fills and full rises; nothing is dropped.
// Limits are written on the cfg port (index 0: max body bytes, index 1: max
// line bytes), which is always ready; write them only while the block is idle.
// Reset empties both queues, clears the decoder and restores default limits.
`timescale 1ns / 1ps
`default_nettype none
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic                              in_new_message,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   out_payload_valid,
  output logic [7:0]                             out_payload_byte,
  output logic [1:0]                             out_status,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [chbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [chbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import chbd_pkg::*;

  logic [BODY_W-1:0] max_body_r;
  logic [LINE_W-1:0] max_line_r;
  logic              item_valid, item_pop;
  item_t             item;
  logic              res_full, res_push;
  result_t           res_in, res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RST;
      max_line_r <= MAX_LINE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_BODY) begin
        max_body_r <= BODY_W'(cfg_data);
      end
      if (cfg_index == CFG_MAX_LINE) begin
        max_line_r <= LINE_W'(cfg_data);
      end
    end
  end

  chbd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .data_byte   (in_data_byte),
    .new_message (in_new_message),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  chbd_engine #(
    .SIZE_BITS (SIZE_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .max_body   (max_body_r),
    .max_line   (max_line_r)
  );

  chbd_fifo #(
    .WIDTH     ($bits(result_t)),
    .ADDR_BITS (1)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_payload_valid = res_out.payload_valid;
  assign out_payload_byte  = res_out.payload_byte;
  assign out_status        = res_out.status;

endmodule
`default_nettype wire

// ----- hdl/chbd_fifo.sv -----
// Small first-in first-out queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`default_nettype none
module chbd_fifo #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int DEPTH = 2 ** ADDR_BITS;

  logic [WIDTH-1:0]     mem_r [DEPTH];
  logic [ADDR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_BITS:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == (ADDR_BITS+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + ADDR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + ADDR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (ADDR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (ADDR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/chbd_front.sv -----
// Front end: takes raw bytes, classifies them and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module chbd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire logic [7:0]     data_byte,
  input  wire logic           new_message,
  output logic                item_valid,
  output chbd_pkg::item_t     item,
  input  wire logic           item_pop
);
  import chbd_pkg::*;

  item_t item_in;
  logic  q_empty;

  always_comb begin
    item_in.data_byte   = data_byte;
    item_in.new_message = new_message;
    item_in.cls         = classify(data_byte);
  end

  chbd_fifo #(
    .WIDTH     ($bits(item_t)),
    .ADDR_BITS (1)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_pop),
    .rdata (item),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;

endmodule
`default_nettype wire

// ----- hdl/chbd_engine.sv -----
// Back end: the chunked framing state machine, one queued word per cycle while the result queue has room.
`timescale 1ns / 1ps
`default_nettype none
module chbd_engine #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    item_valid,
  input  chbd_pkg::item_t              item,
  output logic                         item_pop,
  input  wire logic                    res_full,
  output logic                         res_push,
  output chbd_pkg::result_t            res,
  input  wire logic [chbd_pkg::BODY_W-1:0] max_body,
  input  wire logic [chbd_pkg::LINE_W-1:0] max_line
);
  import chbd_pkg::*;

  localparam int CMP_W = (SIZE_BITS > BODY_W) ? SIZE_BITS : BODY_W;

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_DATA    = 3'd1;
  localparam logic [2:0] PH_DATA_CR = 3'd2;
  localparam logic [2:0] PH_DATA_LF = 3'd3;
  localparam logic [2:0] PH_TRAILER = 3'd4;

  localparam int FL_DIGIT  = 0;
  localparam int FL_TAILWS = 1;
  localparam int FL_EXT    = 2;

  typedef struct packed {
    logic                 bad;
    logic [LINE_W-1:0]    len;
    logic [2:0]           flags;
    logic [SIZE_BITS-1:0] acc;
  } line_st_t;

  logic [2:0]           phase_r, phase_nxt;
  logic [BODY_W-1:0]    chunk_rem_r, chunk_rem_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [2:0]           flags_r, flags_nxt;
  logic                 cr_pend_r, cr_pend_nxt;
  logic [LINE_W-1:0]    line_len_r, line_len_nxt;
  logic [BODY_W-1:0]    body_total_r, body_total_nxt;
  logic [1:0]           status_r, status_nxt;

  logic                 step;
  logic [2:0]           phase_c;
  logic [BODY_W-1:0]    chunk_rem_c, body_total_c, rem_dec;
  logic [SIZE_BITS-1:0] acc_c;
  logic [2:0]           flags_c;
  logic                 cr_pend_c;
  logic [LINE_W-1:0]    line_len_c;
  logic [1:0]           status_c;
  logic [CMP_W-1:0]     acc_ext, budget;
  line_st_t             ls;
  logic                 handled, line_end;
  logic                 pay_valid;

  // One character of a size or trailer line, excluding its CRLF.
  function automatic line_st_t line_char(input line_st_t s, input logic in_size,
                                         input char_cls_t c,
                                         input logic [LINE_W-1:0] lim);
    line_st_t r;
    r = s;
    if (s.len >= lim) begin
      r.bad = 1'b1;
    end else begin
      r.len = s.len + LINE_W'(1);
      if (in_size && !s.flags[FL_EXT]) begin
        if (c.is_semi) begin
          r.flags[FL_EXT] = 1'b1;
        end else if (c.is_ws) begin
          if (s.flags[FL_DIGIT]) begin
            r.flags[FL_TAILWS] = 1'b1;
          end
        end else if (!c.is_hex || s.flags[FL_TAILWS]) begin
          r.bad = 1'b1;
        end else if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
          // Another digit would shift set bits out of the accumulator.
          r.bad = 1'b1;
        end else begin
          r.acc = {s.acc[SIZE_BITS-5:0], c.hex_val};
          r.flags[FL_DIGIT] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  assign step     = item_valid && !res_full;
  assign item_pop = step;
  assign res_push = step;

  always_comb begin
    // A new message starts from the cleared state.
    if (item.new_message) begin
      phase_c      = PH_SIZE;
      chunk_rem_c  = '0;
      acc_c        = '0;
      flags_c      = '0;
      cr_pend_c    = 1'b0;
      line_len_c   = '0;
      body_total_c = '0;
      status_c     = ST_WORK;
    end else begin
      phase_c      = phase_r;
      chunk_rem_c  = chunk_rem_r;
      acc_c        = acc_r;
      flags_c      = flags_r;
      cr_pend_c    = cr_pend_r;
      line_len_c   = line_len_r;
      body_total_c = body_total_r;
      status_c     = status_r;
    end

    phase_nxt      = phase_c;
    chunk_rem_nxt  = chunk_rem_c;
    acc_nxt        = acc_c;
    flags_nxt      = flags_c;
    cr_pend_nxt    = cr_pend_c;
    line_len_nxt   = line_len_c;
    body_total_nxt = body_total_c;
    status_nxt     = status_c;
    pay_valid      = 1'b0;
    handled        = 1'b0;
    line_end       = 1'b0;
    rem_dec        = chunk_rem_c - BODY_W'(1);
    acc_ext        = CMP_W'(acc_c);
    budget         = CMP_W'(max_body - body_total_c);
    ls.bad         = 1'b0;
    ls.len         = line_len_c;
    ls.flags       = flags_c;
    ls.acc         = acc_c;

    if (status_c == ST_WORK) begin
      case (phase_c)
        PH_DATA: begin
          pay_valid      = 1'b1;
          body_total_nxt = body_total_c + BODY_W'(1);
          chunk_rem_nxt  = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (item.cls.is_cr) begin
            phase_nxt = PH_DATA_LF;
          end else begin
            status_nxt = ST_BAD;
          end
        end
        PH_DATA_LF: begin
          if (item.cls.is_lf) begin
            phase_nxt    = PH_SIZE;
            acc_nxt      = '0;
            flags_nxt    = '0;
            cr_pend_nxt  = 1'b0;
            line_len_nxt = '0;
          end else begin
            status_nxt = ST_BAD;
          end
        end
        PH_SIZE, PH_TRAILER: begin
          if (cr_pend_c) begin
            cr_pend_nxt = 1'b0;
            if (item.cls.is_lf) begin
              line_end = 1'b1;
              handled  = 1'b1;
            end else begin
              // The held CR was a plain line character after all.
              ls = line_char(ls, phase_c == PH_SIZE, classify(CH_CR), max_line);
              if (ls.bad) begin
                status_nxt = ST_BAD;
                handled    = 1'b1;
              end
            end
          end
          if (!handled) begin
            if (item.cls.is_cr) begin
              cr_pend_nxt = 1'b1;
            end else begin
              ls = line_char(ls, phase_c == PH_SIZE, item.cls, max_line);
              if (ls.bad) begin
                status_nxt = ST_BAD;
              end
            end
          end
          if (!line_end) begin
            line_len_nxt = ls.len;
            flags_nxt    = ls.flags;
            acc_nxt      = ls.acc;
          end else if (phase_c == PH_TRAILER) begin
            if (line_len_c == '0) begin
              status_nxt = ST_DONE;
            end
            acc_nxt      = '0;
            flags_nxt    = '0;
            line_len_nxt = '0;
          end else if (!flags_c[FL_DIGIT]) begin
            status_nxt = ST_BAD;
          end else if (acc_c == '0) begin
            phase_nxt    = PH_TRAILER;
            acc_nxt      = '0;
            flags_nxt    = '0;
            line_len_nxt = '0;
          end else if (body_total_c > max_body || acc_ext > budget) begin
            status_nxt = ST_BIG;
          end else begin
            chunk_rem_nxt = BODY_W'(acc_ext);
            phase_nxt     = PH_DATA;
            acc_nxt       = '0;
            flags_nxt     = '0;
            line_len_nxt  = '0;
          end
        end
        default: begin
          status_nxt = ST_BAD;
        end
      endcase
    end

    res.payload_valid = pay_valid;
    res.payload_byte  = pay_valid ? item.data_byte : 8'd0;
    res.status        = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      chunk_rem_r  <= '0;
      acc_r        <= '0;
      flags_r      <= '0;
      cr_pend_r    <= 1'b0;
      line_len_r   <= '0;
      body_total_r <= '0;
      status_r     <= ST_WORK;
    end else if (step) begin
      phase_r      <= phase_nxt;
      chunk_rem_r  <= chunk_rem_nxt;
      acc_r        <= acc_nxt;
      flags_r      <= flags_nxt;
      cr_pend_r    <= cr_pend_nxt;
      line_len_r   <= line_len_nxt;
      body_total_r <= body_total_nxt;
      status_r     <= status_nxt;
    end
  end

endmodule
`default_nettype wire
